@@ hw/rtl/ipv6_extension_chain_parser_defines.svh @@
// ----------------------------------------------------------------------------
// IPv6 extension chain parser: assertion macros
// Shared macros for the concurrent checks of the parser RTL.
// ----------------------------------------------------------------------------
`ifndef IPV6_EXTENSION_CHAIN_PARSER_DEFINES_SVH
`define IPV6_EXTENSION_CHAIN_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define IECP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define IECP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/iecp_pkg.sv @@
// ----------------------------------------------------------------------------
// IPv6 extension chain parser package
// Types, constants and helper functions shared by the parser files.
// ----------------------------------------------------------------------------
package iecp_pkg;

   localparam int MAX_PACKET_BYTES = 16384;
   localparam int COUNT_W          = $clog2(MAX_PACKET_BYTES + 1);

   localparam logic [15:0] BASE_LEN   = 16'd40;
   localparam logic [3:0]  IP_VERSION = 4'h6;
   localparam logic [16:0] FRAG_LEN   = 17'd8;

   localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
   localparam logic [7:0] NH_ROUTING    = 8'd43;
   localparam logic [7:0] NH_FRAGMENT   = 8'd44;
   localparam logic [7:0] NH_DEST_OPTS  = 8'd60;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_BAD_VER   = 2'd2,
      STATUS_TRUNCATED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      KIND_BASE     = 3'b001,
      KIND_NEED_LEN = 3'b010,
      KIND_EXT      = 3'b100
   } kind_type;

   function automatic logic is_ext(input logic [7:0] nh);
      return (nh == NH_HOP_BY_HOP) || (nh == NH_ROUTING) ||
             (nh == NH_FRAGMENT) || (nh == NH_DEST_OPTS);
   endfunction

   function automatic logic [15:0] sat16(input logic [16:0] sum);
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

endpackage

@@ hw/rtl/iecp_req_if.sv @@
// ----------------------------------------------------------------------------
// Parser request channel
// Valid/ready channel carrying one packet byte and its end-of-packet flag.
// ----------------------------------------------------------------------------
interface iecp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hw/rtl/iecp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Parser response channel
// Valid/ready channel carrying the per-packet parse summary.
// ----------------------------------------------------------------------------
interface iecp_rsp_if;
   logic                 valid;
   logic                 ready;
   iecp_pkg::status_type status;
   logic [7:0]           upper_protocol;
   logic [15:0]          header_bytes;
   logic [15:0]          payload_bytes;

   modport source (output valid, output status, output upper_protocol,
                   output header_bytes, output payload_bytes, input ready);
   modport sink   (input valid, input status, input upper_protocol,
                   input header_bytes, input payload_bytes, output ready);
endinterface

@@ hw/rtl/ipv6_extension_chain_parser.sv @@
// ----------------------------------------------------------------------------
// IPv6 extension chain parser
// Walks the base header and the extension header chain of a byte stream and
// reports status, upper protocol, header length and payload length per packet.
// ----------------------------------------------------------------------------
// Flow: one byte per cycle, but a last byte waits while an earlier result
//   is unaccepted; every byte passes one input register and one state update.
// Result: the input register loads the last byte at acceptance, and the result
//   register loads when that byte leaves the input register;
//   a result that waits on rsp ready holds the last byte in the input register.
// Reset: synchronous, active high; clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
`include "ipv6_extension_chain_parser_defines.svh"

module ipv6_extension_chain_parser (
   input logic        clock,
   input logic        reset,
   iecp_req_if.sink   req_bus,
   iecp_rsp_if.source rsp_bus
);

   // input stage
   logic       s1_valid_ff;
   logic [7:0] s1_data_ff;
   logic       s1_last_ff;
   logic       s1_go;
   logic       s1_adv;
   logic       req_take;

   // parse state
   logic [iecp_pkg::COUNT_W-1:0] count_ff, count_in;
   iecp_pkg::kind_type           kind_ff, kind_in;
   logic [7:0]                   pend_ff, pend_in;
   logic [15:0]                  end_ff, end_in;
   logic                         done_ff, done_in;
   logic                         fault_ff, fault_in;
   logic [7:0]                   proto_ff, proto_in;

   // result register
   logic                 rsp_valid_ff;
   iecp_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [7:0]           rsp_proto_ff, rsp_proto_in;
   logic [15:0]          rsp_hdr_ff, rsp_hdr_in;
   logic [15:0]          rsp_pay_ff, rsp_pay_in;

   logic [15:0] pos16;
   logic [15:0] total16;
   logic        fin_done;
   logic [7:0]  fin_proto;
   logic [16:0] ext_end_raw;
   logic [16:0] frag_end_raw;
   logic [16:0] rsp_total_chk;

   // a byte without a result never waits on the output side
   assign s1_go    = !s1_last_ff || !rsp_valid_ff || rsp_bus.ready;
   assign s1_adv   = s1_valid_ff && s1_go;
   assign req_bus.ready = !s1_valid_ff || s1_go;
   assign req_take = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
      if (req_take) begin
         s1_data_ff <= req_bus.data_byte;
         s1_last_ff <= req_bus.last_byte;
      end
   end

   assign pos16        = 16'(count_ff);
   assign ext_end_raw  = 17'(pos16) - 17'd1 + 17'({s1_data_ff, 3'b000}) + 17'd8;
   assign frag_end_raw = 17'(pos16) + iecp_pkg::FRAG_LEN;

   // per-byte state update
   always_comb begin
      count_in = count_ff;
      kind_in  = kind_ff;
      pend_in  = pend_ff;
      end_in   = end_ff;
      done_in  = done_ff;
      fault_in = fault_ff;
      proto_in = proto_ff;
      if (32'(count_ff) < iecp_pkg::MAX_PACKET_BYTES) begin
         count_in = count_ff + 1'b1;
         if (count_ff == '0 && s1_data_ff[7:4] != iecp_pkg::IP_VERSION) begin
            fault_in = 1'b1;
         end
         if (pos16 == 16'd6) begin
            pend_in = s1_data_ff;
         end
         if (!done_ff) begin
            if (kind_ff == iecp_pkg::KIND_NEED_LEN) begin
               // length byte: header began one byte earlier
               end_in  = iecp_pkg::sat16(ext_end_raw);
               kind_in = iecp_pkg::KIND_EXT;
            end else if (pos16 == end_ff) begin
               if (iecp_pkg::is_ext(pend_ff)) begin
                  pend_in = s1_data_ff;
                  if (pend_ff == iecp_pkg::NH_FRAGMENT) begin
                     end_in  = iecp_pkg::sat16(frag_end_raw);
                     kind_in = iecp_pkg::KIND_EXT;
                  end else begin
                     kind_in = iecp_pkg::KIND_NEED_LEN;
                  end
               end else begin
                  done_in  = 1'b1;
                  proto_in = pend_ff;
               end
            end
         end
      end
   end

   // end-of-packet summary from the updated state
   assign total16 = 16'(count_in);

   always_comb begin
      fin_done  = done_in;
      fin_proto = proto_in;
      if (!done_in && kind_in != iecp_pkg::KIND_NEED_LEN && total16 == end_in &&
          !iecp_pkg::is_ext(pend_in)) begin
         fin_done  = 1'b1;
         fin_proto = pend_in;
      end
      rsp_status_in = iecp_pkg::STATUS_OK;
      rsp_proto_in  = 8'd0;
      rsp_hdr_in    = 16'd0;
      rsp_pay_in    = 16'd0;
      if (total16 < iecp_pkg::BASE_LEN) begin
         rsp_status_in = iecp_pkg::STATUS_SHORT;
      end else if (fault_in) begin
         rsp_status_in = iecp_pkg::STATUS_BAD_VER;
      end else if (fin_done && end_in <= total16) begin
         rsp_proto_in = fin_proto;
         rsp_hdr_in   = end_in;
         rsp_pay_in   = total16 - end_in;
      end else begin
         rsp_status_in = iecp_pkg::STATUS_TRUNCATED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         kind_ff  <= iecp_pkg::KIND_BASE;
         pend_ff  <= 8'd0;
         end_ff   <= iecp_pkg::BASE_LEN;
         done_ff  <= 1'b0;
         fault_ff <= 1'b0;
         proto_ff <= 8'd0;
      end else if (s1_adv) begin
         if (s1_last_ff) begin
            // packet done: start the next one from scratch
            count_ff <= '0;
            kind_ff  <= iecp_pkg::KIND_BASE;
            pend_ff  <= 8'd0;
            end_ff   <= iecp_pkg::BASE_LEN;
            done_ff  <= 1'b0;
            fault_ff <= 1'b0;
            proto_ff <= 8'd0;
         end else begin
            count_ff <= count_in;
            kind_ff  <= kind_in;
            pend_ff  <= pend_in;
            end_ff   <= end_in;
            done_ff  <= done_in;
            fault_ff <= fault_in;
            proto_ff <= proto_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_adv && s1_last_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_proto_ff  <= rsp_proto_in;
         rsp_hdr_ff    <= rsp_hdr_in;
         rsp_pay_ff    <= rsp_pay_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.upper_protocol = rsp_proto_ff;
   assign rsp_bus.header_bytes   = rsp_hdr_ff;
   assign rsp_bus.payload_bytes  = rsp_pay_ff;

   assign rsp_total_chk = 17'(rsp_hdr_ff) + 17'(rsp_pay_ff);

   `IECP_ASSERT_SAME(a_fault_fields_zero, rsp_valid_ff && rsp_status_ff != iecp_pkg::STATUS_OK, rsp_proto_ff == 8'd0 && rsp_hdr_ff == 16'd0 && rsp_pay_ff == 16'd0, "fault result carries nonzero fields")
   `IECP_ASSERT_SAME(a_ok_lengths, rsp_valid_ff && rsp_status_ff == iecp_pkg::STATUS_OK, rsp_hdr_ff >= iecp_pkg::BASE_LEN && 32'(rsp_total_chk) <= iecp_pkg::MAX_PACKET_BYTES, "ok result lengths out of range")
   `IECP_ASSERT_NEXT(a_state_cleared, s1_adv && s1_last_ff, count_ff == '0 && kind_ff == iecp_pkg::KIND_BASE && !done_ff && !fault_ff, "parse state not cleared after packet end")
   `IECP_ASSERT_NEXT(a_last_beat_held, s1_valid_ff && s1_last_ff && !s1_go, s1_valid_ff && s1_last_ff, "stalled last beat lost from input stage")

endmodule

@@ tb/ipv6_extension_chain_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension chain parser testbench
// Builds IPv6 packets with random extension chains and feeds them one byte per
// beat. A scoreboard walks the same chain in software and checks each packet
// summary field by field. A short table of hand-picked packets comes first,
// followed by mostly well-formed random packets with some noise. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module ipv6_extension_chain_parser_tb;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int N_ROWS      = 15;
   localparam int RAND_BYTES  = 940;
   localparam int RAND_PKTS   = 12;

   typedef struct packed {
      iecp_pkg::status_type status;
      logic [7:0]           proto;
      logic [15:0]          hdr;
      logic [15:0]          pay;
   } parse_summary_type;

   // chain[0] goes in the base header; extension i carries chain[i+1] and, unless it is
   // a fragment header, has length byte lens[i]
   typedef struct packed {
      logic [15:0]          total;
      logic [3:0]           ver;
      logic [0:8][7:0]      chain;
      logic [0:8][7:0]      lens;
      logic                 typed;
      iecp_pkg::status_type status;
      logic [7:0]           proto;
      logic [15:0]          hdr;
      logic [15:0]          pay;
   } packet_row_type;

   // total, version, chain, lens, typed, status, proto, header, payload
   localparam packet_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{16'd1,   4'hF, {8'd6, 64'd0}, 72'd0, 1'b1,
        iecp_pkg::STATUS_SHORT, 8'd0, 16'd0, 16'd0},
      '{16'd39,  4'h4, {8'd6, 64'd0}, 72'd0, 1'b1,
        iecp_pkg::STATUS_SHORT, 8'd0, 16'd0, 16'd0},
      '{16'd40,  4'h6, {8'd6, 64'd0}, 72'd0, 1'b1,
        iecp_pkg::STATUS_OK, 8'd6, 16'd40, 16'd0},
      '{16'd40,  4'h4, {8'd6, 64'd0}, 72'd0, 1'b1,
        iecp_pkg::STATUS_BAD_VER, 8'd0, 16'd0, 16'd0},
      '{16'd40,  4'h0, {8'd0, 64'd0}, 72'd0, 1'b1,
        iecp_pkg::STATUS_BAD_VER, 8'd0, 16'd0, 16'd0},
      '{16'd100, 4'h6, {8'd17, 64'd0}, 72'd0, 1'b1,
        iecp_pkg::STATUS_OK, 8'd17, 16'd40, 16'd60},
      '{16'd60,  4'h6, {8'd255, 64'd0}, 72'd0, 1'b1,
        iecp_pkg::STATUS_OK, 8'd255, 16'd40, 16'd20},
      // hop-by-hop pending when the packet ends
      '{16'd40,  4'h6, {8'd0, 8'd6, 56'd0}, 72'd0, 1'b1,
        iecp_pkg::STATUS_TRUNCATED, 8'd0, 16'd0, 16'd0},
      // hop-by-hop still waiting for its length byte
      '{16'd41,  4'h6, {8'd0, 8'd6, 56'd0}, 72'd0, 1'b1,
        iecp_pkg::STATUS_TRUNCATED, 8'd0, 16'd0, 16'd0},
      '{16'd47,  4'h6, {8'd0, 8'd6, 56'd0}, 72'd0, 1'b1,
        iecp_pkg::STATUS_TRUNCATED, 8'd0, 16'd0, 16'd0},
      '{16'd48,  4'h6, {8'd0, 8'd6, 56'd0}, 72'd0, 1'b1,
        iecp_pkg::STATUS_OK, 8'd6, 16'd48, 16'd0},
      '{16'd56,  4'h6, {8'd44, 8'd44, 8'd6, 48'd0}, 72'd0, 1'b1,
        iecp_pkg::STATUS_OK, 8'd6, 16'd56, 16'd0},
      '{16'd100, 4'h6, {8'd43, 8'd44, 8'd60, 8'd59, 40'd0}, {8'd1, 8'd0, 8'd2, 48'd0},
        1'b0, iecp_pkg::STATUS_OK, 8'd0, 16'd0, 16'd0},
      // largest length byte, header runs past the packet
      '{16'd60,  4'h6, {8'd0, 8'd6, 56'd0}, {8'd255, 64'd0}, 1'b1,
        iecp_pkg::STATUS_TRUNCATED, 8'd0, 16'd0, 16'd0},
      '{16'd300, 4'h6, {8'd43, 8'd17, 56'd0}, {8'd30, 64'd0}, 1'b0,
        iecp_pkg::STATUS_OK, 8'd0, 16'd0, 16'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   iecp_req_if req_bus ();
   iecp_rsp_if rsp_bus ();

   ipv6_extension_chain_parser u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   parse_summary_type summary_q [$];
   logic [7:0]        packet_bytes [$];
   logic [7:0]        ext_kinds [4] = '{iecp_pkg::NH_HOP_BY_HOP, iecp_pkg::NH_ROUTING,
                                        iecp_pkg::NH_FRAGMENT, iecp_pkg::NH_DEST_OPTS};

   bit no_idle = 1'b0;
   int cycle_count = 0;
   int error_count = 0;
   int packets_sent = 0;
   int bytes_sent = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   // chain walker state
   int                 byte_cnt;
   iecp_pkg::kind_type walk_kind;
   logic [7:0]         next_hdr;
   int                 hdr_end;
   bit                 chain_found;
   bit                 ver_fault;
   logic [7:0]         upper_nh;

   function automatic bit ext_header(input logic [7:0] nh);
      return nh == iecp_pkg::NH_HOP_BY_HOP || nh == iecp_pkg::NH_ROUTING ||
             nh == iecp_pkg::NH_FRAGMENT || nh == iecp_pkg::NH_DEST_OPTS;
   endfunction

   function automatic int clip16(input int v);
      return (v > 65535) ? 65535 : v;
   endfunction

   task automatic clear_walk();
      byte_cnt    = 0;
      walk_kind   = iecp_pkg::KIND_BASE;
      next_hdr    = 8'd0;
      hdr_end     = int'(iecp_pkg::BASE_LEN);
      chain_found = 1'b0;
      ver_fault   = 1'b0;
      upper_nh    = 8'd0;
   endtask

   // advance the chain walk by one byte; summary is meaningful on the last byte
   task automatic parse_byte(input logic [7:0] b, input logic last,
                             output parse_summary_type res);
      int         pos;
      logic [7:0] this_nh;
      res = '0;
      pos = byte_cnt;
      if (pos < iecp_pkg::MAX_PACKET_BYTES) begin
         byte_cnt = pos + 1;
         if (pos == 0 && b[7:4] != iecp_pkg::IP_VERSION) ver_fault = 1'b1;
         if (pos == 6) next_hdr = b;
         if (!chain_found) begin
            if (walk_kind == iecp_pkg::KIND_NEED_LEN) begin
               // length byte; the header started one byte earlier
               hdr_end   = clip16(pos - 1 + (int'(b) + 1) * 8);
               walk_kind = iecp_pkg::KIND_EXT;
            end else if (pos == hdr_end) begin
               if (ext_header(next_hdr)) begin
                  this_nh  = next_hdr;
                  next_hdr = b;
                  if (this_nh == iecp_pkg::NH_FRAGMENT) begin
                     hdr_end   = clip16(pos + int'(iecp_pkg::FRAG_LEN));
                     walk_kind = iecp_pkg::KIND_EXT;
                  end else begin
                     walk_kind = iecp_pkg::KIND_NEED_LEN;
                  end
               end else begin
                  chain_found = 1'b1;
                  upper_nh    = next_hdr;
               end
            end
         end
      end
      if (last) begin
         if (byte_cnt < int'(iecp_pkg::BASE_LEN)) begin
            res.status = iecp_pkg::STATUS_SHORT;
         end else if (ver_fault) begin
            res.status = iecp_pkg::STATUS_BAD_VER;
         end else begin
            // headers that end exactly on the last byte
            if (!chain_found && walk_kind != iecp_pkg::KIND_NEED_LEN &&
                byte_cnt == hdr_end && !ext_header(next_hdr)) begin
               chain_found = 1'b1;
               upper_nh    = next_hdr;
            end
            if (chain_found && hdr_end <= byte_cnt) begin
               res.proto = upper_nh;
               res.hdr   = 16'(hdr_end);
               res.pay   = 16'(byte_cnt - hdr_end);
            end else begin
               res.status = iecp_pkg::STATUS_TRUNCATED;
            end
         end
         clear_walk();
      end
   endtask

   task automatic build_packet(input packet_row_type row);
      int         i;
      int         k;
      int         span;
      logic [7:0] b;
      packet_bytes.delete();
      for (k = 0; k < int'(iecp_pkg::BASE_LEN); k++) packet_bytes.push_back(8'($urandom));
      packet_bytes[0] = {row.ver, 4'($urandom)};
      packet_bytes[6] = row.chain[0];
      i = 0;
      while (i < 8 && ext_header(row.chain[i]) && packet_bytes.size() < row.total) begin
         span = (row.chain[i] == iecp_pkg::NH_FRAGMENT) ? int'(iecp_pkg::FRAG_LEN)
                                                        : (int'(row.lens[i]) + 1) * 8;
         for (k = 0; k < span; k++) begin
            b = 8'($urandom);
            if (k == 0) b = row.chain[i + 1];
            else if (k == 1 && row.chain[i] != iecp_pkg::NH_FRAGMENT) b = row.lens[i];
            packet_bytes.push_back(b);
         end
         i++;
      end
      while (packet_bytes.size() < row.total) packet_bytes.push_back(8'($urandom));
      while (packet_bytes.size() > row.total) void'(packet_bytes.pop_back());
   endtask

   task automatic send_packet(input packet_row_type row);
      parse_summary_type got;
      parse_summary_type typed_res;
      int                gap;
      int                k;
      logic              last;
      for (k = 0; k < packet_bytes.size(); k++) begin
         gap = no_idle ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         last = (k == packet_bytes.size() - 1);
         req_bus.valid     <= 1'b1;
         req_bus.data_byte <= packet_bytes[k];
         req_bus.last_byte <= last;
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         parse_byte(packet_bytes[k], last, got);
         if (last) begin
            if (row.typed) begin
               typed_res.status = row.status;
               typed_res.proto  = row.proto;
               typed_res.hdr    = row.hdr;
               typed_res.pay    = row.pay;
               summary_q.push_back(typed_res);
            end else begin
               summary_q.push_back(got);
            end
         end
      end
      bytes_sent += packet_bytes.size();
      packets_sent++;
   endtask

   // hold the input idle until every summary has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (summary_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d summaries outstanding",
                  cycle_count, summary_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stalls, then compare with the oldest expectation
   initial begin
      parse_summary_type want;
      int                stall;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         if (summary_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: cycle %0d: summary with none expected (status %0d)",
                        cycle_count, rsp_bus.status);
         end else begin
            want = summary_q.pop_front();
            status_seen[int'(want.status)]++;
            if (rsp_bus.status !== want.status || rsp_bus.upper_protocol !== want.proto ||
                rsp_bus.header_bytes !== want.hdr || rsp_bus.payload_bytes !== want.pay) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: cycle %0d: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           cycle_count, want.status, want.proto, want.hdr, want.pay,
                           rsp_bus.status, rsp_bus.upper_protocol, rsp_bus.header_bytes,
                           rsp_bus.payload_bytes);
            end
         end
      end
   end

   initial begin
      packet_row_type row;
      int             r;
      int             j;
      int             n_ext;
      int             hdr_len;
      int             pick;
      int             rand_bytes;
      int             rand_pkts;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'd0;
      req_bus.last_byte <= 1'b0;
      clear_walk();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < N_ROWS; r++) begin
         no_idle = ($urandom_range(0, 3) == 0);
         build_packet(DIRECTED_ROWS[r]);
         send_packet(DIRECTED_ROWS[r]);
      end
      drain_results();

      rand_bytes = 0;
      rand_pkts  = 0;
      while (rand_bytes < RAND_BYTES || rand_pkts < RAND_PKTS) begin
         row = '0;
         for (j = 0; j < 9; j++) begin
            row.chain[j] = 8'($urandom);
            row.lens[j]  = 8'($urandom_range(0, 3));
         end
         if ($urandom_range(0, 99) < 20) begin
            // noise: anything goes
            row.ver   = 4'($urandom);
            row.total = 16'($urandom_range(1, 80));
         end else begin
            row.ver = ($urandom_range(0, 19) == 0) ? 4'($urandom) : iecp_pkg::IP_VERSION;
            n_ext   = $urandom_range(0, 4);
            hdr_len = int'(iecp_pkg::BASE_LEN);
            for (j = 0; j < n_ext; j++) begin
               row.chain[j] = ext_kinds[$urandom_range(0, 3)];
               if ($urandom_range(0, 9) == 0) row.lens[j] = 8'($urandom_range(0, 31));
               hdr_len += (row.chain[j] == iecp_pkg::NH_FRAGMENT)
                          ? int'(iecp_pkg::FRAG_LEN) : (int'(row.lens[j]) + 1) * 8;
            end
            if ($urandom_range(0, 9) == 0) begin
               row.chain[n_ext] = ext_kinds[$urandom_range(0, 3)];
            end else begin
               do row.chain[n_ext] = 8'($urandom); while (ext_header(row.chain[n_ext]));
            end
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               row.total = 16'(hdr_len + $urandom_range(0, 24));
            end else if (pick < 95) begin
               row.total = 16'($urandom_range(int'(iecp_pkg::BASE_LEN), hdr_len + 1));
            end else begin
               row.total = 16'($urandom_range(1, 45));
            end
         end
         no_idle = ($urandom_range(0, 3) == 0);
         build_packet(row);
         send_packet(row);
         rand_bytes += row.total;
         rand_pkts++;
         if (rand_pkts % 8 == 0) drain_results();
      end

      drain_results();
      repeat (20) @(posedge clock);
      $display("Sent %0d packets, %0d bytes, %0d of them from the directed table",
               packets_sent, bytes_sent, N_ROWS);
      $display("Summaries: ok %0d, short %0d, bad version %0d, truncated %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
